FILE: src/ibmp_pkg.sv
// Package for the interleaved block memory port.
// Holds the transfer types, action and opcode codes, and the control structs.
// Has no dependencies.
`timescale 1ns / 1ps

package ibmp_pkg;

	localparam int MEM_ADDR_BITS = 20;
	localparam int CHUNK_LOG2    = 6;
	localparam int CHUNK_BYTES   = 1 << CHUNK_LOG2;
	localparam int BLOCK_LOG2    = CHUNK_LOG2 + 1;
	localparam int CTR_BITS      = 32;
	localparam int MIN_CMD_LEN   = 8;

	localparam logic [2:0] ACT_COMMAND    = 3'd0;
	localparam logic [2:0] ACT_WRITE_EVEN = 3'd1;
	localparam logic [2:0] ACT_WRITE_ODD  = 3'd2;
	localparam logic [2:0] ACT_READ_EVEN  = 3'd3;
	localparam logic [2:0] ACT_READ_ODD   = 3'd4;

	localparam logic [7:0] OP_A = 8'h0D;
	localparam logic [7:0] OP_B = 8'h10;
	localparam logic [7:0] OP_C = 8'h0C;
	localparam logic [7:0] OP_D = 8'h11;

	localparam logic [7:0] ERASED_BYTE = 8'hFF;

	typedef struct packed {
		logic [2:0]  action;
		logic [7:0]  opcode;
		logic [31:0] start_address;
		logic [7:0]  command_length;
		logic [7:0]  write_byte;
		logic        packet_end;
	} req_item_t;

	typedef struct packed {
		logic [7:0] read_byte;
		logic       out_of_range;
		logic       response_end;
	} rsp_item_t;

	typedef struct packed {
		logic accept;
		logic clear_step;
		logic load_out;
	} ctrl_cmd_t;

	typedef struct packed {
		logic clear_done;
		logic req_is_read;
		logic out_free;
	} ctrl_sts_t;

endpackage

FILE: src/ibmp_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps

module ibmp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end else begin
				rdata_q <= mem[addr];
			end
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: src/ibmp_ctrl.sv
// Controller for the interleaved block memory port: clear pass, run, read wait.
// Depends on ibmp_pkg.
`timescale 1ns / 1ps

module ibmp_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	input  ibmp_pkg::ctrl_sts_t sts,
	output ibmp_pkg::ctrl_cmd_t cmd
);

	localparam logic [1:0] ST_CLEAR = 2'd0;
	localparam logic [1:0] ST_RUN   = 2'd1;
	localparam logic [1:0] ST_READ  = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;

	always_comb begin
		state_d        = state_q;
		req_ready      = 1'b0;
		cmd.accept     = 1'b0;
		cmd.clear_step = 1'b0;
		cmd.load_out   = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				cmd.clear_step = 1'b1;
				if (sts.clear_done) begin
					state_d = ST_RUN;
				end
			end
			ST_RUN: begin
				req_ready  = 1'b1;
				cmd.accept = req_valid;
				if (req_valid && sts.req_is_read) begin
					state_d = ST_READ;
				end
			end
			ST_READ: begin
				cmd.load_out = sts.out_free;
				if (sts.out_free) begin
					state_d = ST_RUN;
				end
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

FILE: src/ibmp_datapath.sv
// Datapath: block counters, chunk offset, address, byte store and result register.
// Depends on ibmp_pkg and ibmp_ram.
`timescale 1ns / 1ps

module ibmp_datapath #(
	parameter int MEM_ADDR_BITS = ibmp_pkg::MEM_ADDR_BITS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ibmp_pkg::req_item_t  req,
	output logic                 rsp_valid,
	input  logic                 rsp_ready,
	output ibmp_pkg::rsp_item_t  rsp,
	input  ibmp_pkg::ctrl_cmd_t  cmd,
	output ibmp_pkg::ctrl_sts_t  sts
);

	localparam int CW = ibmp_pkg::CTR_BITS;
	localparam int OW = ibmp_pkg::CHUNK_LOG2;
	localparam int FW = CW + 1 + OW;

	logic [CW-1:0] even_rd_q, odd_rd_q, even_wr_q, odd_wr_q;
	logic [OW-1:0] offset_q;
	logic [MEM_ADDR_BITS-1:0] clr_cnt_q;
	logic          rd_oor_q, rd_end_q;
	logic          rsp_valid_q;
	ibmp_pkg::rsp_item_t rsp_q;

	logic [CW-1:0] blk_sel;
	logic          odd_sel, is_write, is_read, cmd_ok, oor, advance;
	logic [FW-1:0] addr_full;
	logic [MEM_ADDR_BITS-1:0] ram_addr;
	logic [7:0]    ram_wdata, ram_rdata;
	logic          ram_en, ram_we;

	always_comb begin
		blk_sel  = even_wr_q;
		odd_sel  = 1'b0;
		is_write = 1'b0;
		is_read  = 1'b0;
		case (req.action)
			ibmp_pkg::ACT_WRITE_EVEN: begin
				is_write = 1'b1;
			end
			ibmp_pkg::ACT_WRITE_ODD: begin
				blk_sel  = odd_wr_q;
				odd_sel  = 1'b1;
				is_write = 1'b1;
			end
			ibmp_pkg::ACT_READ_EVEN: begin
				blk_sel = even_rd_q;
				is_read = 1'b1;
			end
			ibmp_pkg::ACT_READ_ODD: begin
				blk_sel = odd_rd_q;
				odd_sel = 1'b1;
				is_read = 1'b1;
			end
			default: begin
				blk_sel = even_wr_q;
			end
		endcase
	end

	assign cmd_ok = (req.action == ibmp_pkg::ACT_COMMAND)
		&& (req.command_length >= 8'(ibmp_pkg::MIN_CMD_LEN))
		&& (req.opcode inside {ibmp_pkg::OP_A, ibmp_pkg::OP_B,
			ibmp_pkg::OP_C, ibmp_pkg::OP_D});

	// block * 128 + offset (+64 for odd) is a plain concatenation
	assign addr_full = {blk_sel, odd_sel, offset_q};
	assign oor       = |addr_full[FW-1:MEM_ADDR_BITS];
	assign advance   = req.packet_end || (offset_q == OW'(ibmp_pkg::CHUNK_BYTES - 1));

	assign ram_en    = cmd.clear_step || (cmd.accept && (is_write || is_read) && !oor);
	assign ram_we    = cmd.clear_step || is_write;
	assign ram_addr  = cmd.clear_step ? clr_cnt_q : addr_full[MEM_ADDR_BITS-1:0];
	assign ram_wdata = cmd.clear_step ? ibmp_pkg::ERASED_BYTE : req.write_byte;

	ibmp_ram #(
		.WIDTH(8),
		.DEPTH(1 << MEM_ADDR_BITS)
	) u_ram (
		.clk  (clk),
		.en   (ram_en),
		.we   (ram_we),
		.addr (ram_addr),
		.wdata(ram_wdata),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			even_rd_q <= '0;
			odd_rd_q  <= '0;
			even_wr_q <= '0;
			odd_wr_q  <= '0;
			offset_q  <= '0;
			clr_cnt_q <= '0;
		end else begin
			if (cmd.clear_step) begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
			end
			if (cmd.accept) begin
				if (cmd_ok) begin
					even_rd_q <= CW'(req.start_address[31:ibmp_pkg::BLOCK_LOG2]);
					odd_rd_q  <= CW'(req.start_address[31:ibmp_pkg::BLOCK_LOG2]);
					even_wr_q <= CW'(req.start_address[31:ibmp_pkg::BLOCK_LOG2]);
					odd_wr_q  <= CW'(req.start_address[31:ibmp_pkg::BLOCK_LOG2]);
					offset_q  <= '0;
				end else if (is_write || is_read) begin
					if (advance) begin
						offset_q <= '0;
						case (req.action)
							ibmp_pkg::ACT_WRITE_EVEN: even_wr_q <= even_wr_q + 1'b1;
							ibmp_pkg::ACT_WRITE_ODD:  odd_wr_q  <= odd_wr_q + 1'b1;
							ibmp_pkg::ACT_READ_EVEN:  even_rd_q <= even_rd_q + 1'b1;
							ibmp_pkg::ACT_READ_ODD:   odd_rd_q  <= odd_rd_q + 1'b1;
							default: ;
						endcase
					end else begin
						offset_q <= offset_q + 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept && is_read) begin
			rd_oor_q <= oor;
			rd_end_q <= req.packet_end;
		end
		if (cmd.load_out) begin
			rsp_q.read_byte    <= rd_oor_q ? ibmp_pkg::ERASED_BYTE : ram_rdata;
			rsp_q.out_of_range <= rd_oor_q;
			rsp_q.response_end <= rd_end_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	assign rsp_valid       = rsp_valid_q;
	assign rsp             = rsp_q;
	assign sts.clear_done  = &clr_cnt_q;
	assign sts.req_is_read = is_read;
	assign sts.out_free    = !rsp_valid_q || rsp_ready;

endmodule

FILE: src/interleaved_block_memory_port_unit.sv
// Interleaved block memory port: two byte streams over one byte store.
// A read's byte is registered by the RAM, then by the result register once the output is free.
// Throughput: 1 write or command per cycle; a read holds req_ready low until its byte is loaded.
// Reset: asynchronous; counters clear at once, then a clearing pass writes 0xFF to
// every byte, with req_ready low throughout.
`timescale 1ns / 1ps

module interleaved_block_memory_port_unit #(
	parameter int MEM_ADDR_BITS = ibmp_pkg::MEM_ADDR_BITS
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	input  ibmp_pkg::req_item_t req,
	output logic                rsp_valid,
	input  logic                rsp_ready,
	output ibmp_pkg::rsp_item_t rsp
);

	ibmp_pkg::ctrl_cmd_t cmd;
	ibmp_pkg::ctrl_sts_t sts;

	ibmp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	ibmp_datapath #(
		.MEM_ADDR_BITS(MEM_ADDR_BITS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp      (rsp),
		.cmd      (cmd),
		.sts      (sts)
	);

endmodule

FILE: src/ibmp_checker.sv
// Port-level checks for the interleaved block memory port, bound to the top level.
// Depends on ibmp_pkg and interleaved_block_memory_port_unit.
`timescale 1ns / 1ps

module ibmp_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                req_valid,
	input logic                req_ready,
	input ibmp_pkg::req_item_t req,
	input logic                rsp_valid,
	input logic                rsp_ready,
	input ibmp_pkg::rsp_item_t rsp
);

	logic rd_xfer;

	assign rd_xfer = req_valid && req_ready
		&& (req.action == ibmp_pkg::ACT_READ_EVEN || req.action == ibmp_pkg::ACT_READ_ODD);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("rsp changed while stalled");

	a_read_stall: assert property (@(posedge clk) disable iff (!arst_n)
		rd_xfer |=> !req_ready)
		else $error("req taken while a read is in flight");

	a_read_latency: assert property (@(posedge clk) disable iff (!arst_n)
		rd_xfer && !rsp_valid |-> ##2 rsp_valid)
		else $error("read result missing two cycles after transfer");

	a_oor_byte: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.out_of_range |-> rsp.read_byte == ibmp_pkg::ERASED_BYTE)
		else $error("out-of-range read did not return 0xFF");

endmodule

bind interleaved_block_memory_port_unit ibmp_checker u_ibmp_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.req_valid(req_valid),
	.req_ready(req_ready),
	.req      (req),
	.rsp_valid(rsp_valid),
	.rsp_ready(rsp_ready),
	.rsp      (rsp)
);
